### rtl/ffn_pkg.sv
package ffn_pkg;

  localparam int COORD_BITS  = 24;
  localparam int NORMAL_BITS = 16;

  // edge vectors, products and cross product components
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int BLW = $clog2(CW + 1);

  // degeneracy test: any component at or above 2^SMALL_BITS clears the limit
  localparam int SMALL_BITS = 19;
  localparam int SSQW = 2 * SMALL_BITS + 2;
  localparam logic [63:0] DEGEN_LIMIT = 64'd184467440737;

  // scaled magnitudes, sum of squares and its root
  localparam int SW   = 31;
  localparam int SQW  = 2 * SW + 2;
  localparam int RW   = SQW / 2;
  localparam int REMW = RW + 4;
  localparam int NSQ  = RW / 2;

  // normalising divide
  localparam int FB    = NORMAL_BITS - 2;
  localparam int QB    = FB + 1;
  localparam int NUMW  = SW + FB + 1;
  localparam int DSTEP = 3;
  localparam int NDIV  = (QB + DSTEP - 1) / DSTEP;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][SW-1:0] sc;
    logic [2:0]         neg;
    logic               degen;
  } side_t;

  typedef struct packed {
    logic [2:0][NUMW-1:0] rem;
    logic [2:0][QB-1:0]   q;
    logic [RW-1:0]        len;
    logic [2:0]           neg;
    logic                 degen;
  } div_t;

endpackage

### rtl/ffn_isqrt.sv
module ffn_isqrt (
  input  logic                     clk,
  input  logic [ffn_pkg::NSQ-1:0]  en,
  input  logic [ffn_pkg::SQW-1:0]  s_in,
  output logic [ffn_pkg::RW-1:0]   root
);

  localparam int NSQ  = ffn_pkg::NSQ;
  localparam int SQW  = ffn_pkg::SQW;
  localparam int RW   = ffn_pkg::RW;
  localparam int REMW = ffn_pkg::REMW;

  function automatic ffn_pkg::sqrt_t sqrt_step(ffn_pkg::sqrt_t st, logic [1:0] pair);
    logic [REMW-1:0] r;
    logic [REMW-1:0] t;
    ffn_pkg::sqrt_t  o;
    r = {st.rem[REMW-3:0], pair};
    t = {{(REMW-RW-2){1'b0}}, st.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {st.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {st.root[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  ffn_pkg::sqrt_t st_q [NSQ];
  logic [SQW-1:0] s_q  [NSQ-1];

  // two root bits per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_stg
    ffn_pkg::sqrt_t st_in;
    ffn_pkg::sqrt_t st_mid;
    ffn_pkg::sqrt_t st_out;
    logic [SQW-1:0] s_cur;

    if (k == 0) begin : g_first
      assign st_in = '0;
      assign s_cur = s_in;
    end else begin : g_rest
      assign st_in = st_q[k-1];
      assign s_cur = s_q[k-1];
    end

    always_comb begin
      st_mid = sqrt_step(st_in, s_cur[SQW-1 -: 2]);
      st_out = sqrt_step(st_mid, s_cur[SQW-3 -: 2]);
    end

    always_ff @(posedge clk) begin
      if (en[k]) st_q[k] <= st_out;
    end

    if (k < NSQ - 1) begin : g_s
      always_ff @(posedge clk) begin
        if (en[k]) s_q[k] <= {s_cur[SQW-5:0], 4'b0000};
      end
    end
  end

  assign root = st_q[NSQ-1].root;

endmodule

### rtl/flat_face_normal_unit.sv
// Unit normal of a flat face.
// Input channel (in_valid/in_ready): one word carries the three corners a, b, c
// in signed Q8.16. Output channel (out_valid/out_ready): one word carries the
// Q1.14 unit normal of cross(b - a, c - a) and the degenerate flag; a face
// whose squared cross product is at or below 1e-8 gives (0, 1, 0) with the
// flag set. Quads are fed as their first three corners.
// Depth: 31 register stages. Throughput: one face per cycle unless a
// stalled receiver holds the whole pipe full. The depth is set by the square
// root (16 stages, two root bits each) and the divide (5 stages, three quotient
// bits each per component); the front end takes 8 stages, the numerator 1
// and the result register 1.
// Reset clears every stage valid bit; data registers are not reset.
// When the receiver stalls, the result register holds its word and stages
// behind it keep filling any empty slots, so in_ready stays high until the
// whole pipe is full. Nothing is dropped or repeated.
module flat_face_normal_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] ax,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] ay,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] az,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] bx,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] by_coord,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] bz,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] cx,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] cy,
  input  logic signed [ffn_pkg::COORD_BITS-1:0] cz,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ffn_pkg::NORMAL_BITS-1:0] normal_x,
  output logic signed [ffn_pkg::NORMAL_BITS-1:0] normal_y,
  output logic signed [ffn_pkg::NORMAL_BITS-1:0] normal_z,
  output logic                                  degenerate
);

  localparam int CB    = ffn_pkg::COORD_BITS;
  localparam int NB    = ffn_pkg::NORMAL_BITS;
  localparam int DW    = ffn_pkg::DW;
  localparam int PW    = ffn_pkg::PW;
  localparam int CW    = ffn_pkg::CW;
  localparam int BLW   = ffn_pkg::BLW;
  localparam int SB    = ffn_pkg::SMALL_BITS;
  localparam int SSQW  = ffn_pkg::SSQW;
  localparam int SW    = ffn_pkg::SW;
  localparam int SQW   = ffn_pkg::SQW;
  localparam int RW    = ffn_pkg::RW;
  localparam int NSQ   = ffn_pkg::NSQ;
  localparam int FB    = ffn_pkg::FB;
  localparam int QB    = ffn_pkg::QB;
  localparam int NUMW  = ffn_pkg::NUMW;
  localparam int DSTEP = ffn_pkg::DSTEP;
  localparam int NDIV  = ffn_pkg::NDIV;

  localparam int P_SQ0  = 8;
  localparam int P_NUM  = P_SQ0 + NSQ;
  localparam int P_DIV0 = P_NUM + 1;
  localparam int P_OUT  = P_DIV0 + NDIV;
  localparam int NST    = P_OUT + 1;

  // stage valids and hold-aware enables
  logic [NST-1:0] vld;
  logic [NST-1:0] vld_in;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign vld_in   = {vld[NST-2:0], in_valid};
  assign in_ready = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) vld[i] <= vld_in[i];
      end
    end
  end

  // stage 0: edges
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux <= {bx[CB-1], bx} - {ax[CB-1], ax};
      uy <= {by_coord[CB-1], by_coord} - {ay[CB-1], ay};
      uz <= {bz[CB-1], bz} - {az[CB-1], az};
      vx <= {cx[CB-1], cx} - {ax[CB-1], ax};
      vy <= {cy[CB-1], cy} - {ay[CB-1], ay};
      vz <= {cz[CB-1], cz} - {az[CB-1], az};
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_yz <= uy * vz;
      p_zy <= uz * vy;
      p_zx <= uz * vx;
      p_xz <= ux * vz;
      p_xy <= ux * vy;
      p_yx <= uy * vx;
    end
  end

  // stage 2: cross product
  logic signed [CW-1:0] cr [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cr[0] <= {p_yz[PW-1], p_yz} - {p_zy[PW-1], p_zy};
      cr[1] <= {p_zx[PW-1], p_zx} - {p_xz[PW-1], p_xz};
      cr[2] <= {p_xy[PW-1], p_xy} - {p_yx[PW-1], p_yx};
    end
  end

  // stage 3: sign and magnitude
  logic [2:0][CW-1:0] mag3;
  logic [2:0]         neg3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= cr[i][CW-1];
        mag3[i] <= cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
      end
    end
  end

  // stage 4: small squares for the limit test, bit length of the largest
  logic [2:0][CW-1:0]     mag4;
  logic [2:0]             neg4;
  logic [2:0][2*SB-1:0]   sq4;
  logic                   small4;
  logic [BLW-1:0]         blen4;
  logic [CW-1:0]          orv;
  logic [BLW-1:0]         blen;

  always_comb begin
    orv  = mag3[0] | mag3[1] | mag3[2];
    blen = '0;
    for (int i = 0; i < CW; i++) begin
      if (orv[i]) blen = BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= mag3[i][SB-1:0] * mag3[i][SB-1:0];
      end
      small4 <= (mag3[0][CW-1:SB] == '0) && (mag3[1][CW-1:SB] == '0)
                && (mag3[2][CW-1:SB] == '0);
      blen4  <= blen;
      mag4   <= mag3;
      neg4   <= neg3;
    end
  end

  // stage 5: limit test, scale so the largest magnitude sits in [2^30, 2^31)
  ffn_pkg::side_t side5;
  logic [SSQW-1:0] ssum;
  logic [2:0][SW-1:0] sc5;
  logic [CW+SW-1:0] ext [3];

  always_comb begin
    ssum = SSQW'(sq4[0]) + SSQW'(sq4[1]) + SSQW'(sq4[2]);
    for (int i = 0; i < 3; i++) begin
      ext[i] = {mag4[i], {SW{1'b0}}} >> blen4;
      sc5[i] = ext[i][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      side5.degen <= small4 && (64'(ssum) <= ffn_pkg::DEGEN_LIMIT);
      side5.sc    <= sc5;
      side5.neg   <= neg4;
    end
  end

  // stage 6: squares of the scaled magnitudes
  ffn_pkg::side_t side6;
  logic [2:0][2*SW-1:0] sq6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= side5.sc[i] * side5.sc[i];
      end
      side6 <= side5;
    end
  end

  // stage 7: sum of squares
  ffn_pkg::side_t side7;
  logic [SQW-1:0] s2;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s2    <= SQW'(sq6[0]) + SQW'(sq6[1]) + SQW'(sq6[2]);
      side7 <= side6;
    end
  end

  // square root, side data carried alongside
  logic [RW-1:0] root;
  ffn_pkg::side_t side_q [NSQ];

  ffn_isqrt u_isqrt (
    .clk  (clk),
    .en   (en[P_SQ0 +: NSQ]),
    .s_in (s2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSQ; k++) begin
      if (en[P_SQ0+k]) side_q[k] <= (k == 0) ? side7 : side_q[(k == 0) ? 0 : k - 1];
    end
  end

  // numerators with rounding half
  ffn_pkg::div_t dv [NDIV+1];
  ffn_pkg::side_t sd;

  assign sd = side_q[NSQ-1];

  always_ff @(posedge clk) begin
    if (en[P_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        dv[0].rem[i] <= NUMW'({sd.sc[i], {FB{1'b0}}}) + NUMW'(root >> 1);
      end
      dv[0].q     <= '0;
      dv[0].len   <= root;
      dv[0].neg   <= sd.neg;
      dv[0].degen <= sd.degen;
    end
  end

  // restoring divide, DSTEP quotient bits per stage
  for (genvar d = 0; d < NDIV; d++) begin : g_div
    ffn_pkg::div_t t;

    always_comb begin
      logic [NUMW:0] dsr;
      int k;
      t = dv[d];
      for (int j = 0; j < DSTEP; j++) begin
        k = QB - 1 - (d * DSTEP + j);
        if (k >= 0) begin
          dsr = (NUMW + 1)'(t.len) << k;
          for (int l = 0; l < 3; l++) begin
            if ({1'b0, t.rem[l]} >= dsr) begin
              t.rem[l] = t.rem[l] - dsr[NUMW-1:0];
              t.q[l][k] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[P_DIV0+d]) dv[d+1] <= t;
    end
  end

  // result register
  ffn_pkg::div_t dq;
  logic signed [NB-1:0] nv [3];

  assign dq = dv[NDIV];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = dq.neg[i] ? -NB'(dq.q[i]) : NB'(dq.q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_OUT]) begin
      if (dq.degen) begin
        normal_x <= '0;
        normal_y <= {1'b0, 1'b1, {FB{1'b0}}};
        normal_z <= '0;
      end else begin
        normal_x <= nv[0];
        normal_y <= nv[1];
        normal_z <= nv[2];
      end
      degenerate <= dq.degen;
    end
  end

  a_degen_fallback : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_z == '0)
    else $error("degenerate word without fallback normal");

  a_unit_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |->
      normal_x <= $signed(NB'(1) << FB) && normal_x >= -$signed(NB'(1) << FB)
      && normal_y <= $signed(NB'(1) << FB) && normal_y >= -$signed(NB'(1) << FB)
      && normal_z <= $signed(NB'(1) << FB) && normal_z >= -$signed(NB'(1) << FB))
    else $error("normal component beyond unit length");

  a_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("non-degenerate face gave zero normal");

  a_empty_out_accepts : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty result register");

  a_ready_passes : assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input held off while receiver takes words");

endmodule
